// ===== sv/cbts_pkg.sv =====
// shared types, constants and helper functions for the can bit timing search
package cbts_pkg;

    localparam int DIVD_W        = 52;
    localparam int DIVS_W        = 36;
    localparam int COST_W        = 60;
    localparam int QUANTA_SPREAD = 25;
    localparam int PRESC_MAX     = 1023;
    localparam int SEG1_MAX      = 16;
    localparam int SEG2_MAX      = 8;

    localparam logic [1:0] REG_CLOCK_HZ      = 2'd0;
    localparam logic [1:0] REG_BAUD_WEIGHT   = 2'd1;
    localparam logic [1:0] REG_SAMPLE_WEIGHT = 2'd2;
    localparam logic [1:0] REG_QUANTA_WEIGHT = 2'd3;

    typedef struct packed {
        logic [19:0] bit_rate;
        logic [15:0] sample_pos;
    } t_in;

    typedef struct packed {
        logic [9:0] prescaler;
        logic [4:0] segment_one;
        logic [3:0] segment_two;
        logic [2:0] jump_width;
        logic [4:0] quanta_per_bit;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_SEG, ST_DIV_R, ST_PRESC, ST_DEN, ST_BST,
        ST_DIV_B, ST_DIV_S, ST_PROD, ST_COST, ST_NEXT, ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        DIV_PRESC, DIV_BAUD, DIV_SAMPLE
    } t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul;
        logic     seg;
        logic     div_start;
        t_div_sel div_sel;
        logic     presc;
        logic     den;
        logic     save_eb;
        logic     save_es;
        logic     prod;
        logic     cost;
        logic     step_n;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic skip;
        logic last_n;
        logic out_full;
    } t_sts;

    typedef logic [15:0] t_eq_tab [32];

    function automatic t_eq_tab eq_table(int nom);
        t_eq_tab tab;
        int      gap;
        for (int k = 0; k < 32; k++) begin
            gap    = (k > nom) ? k - nom : nom - k;
            tab[k] = 16'((gap * 65536) / QUANTA_SPREAD);
        end
        return tab;
    endfunction

endpackage

// ===== sv/cbts_div.sv =====
// restoring divider, one quotient bit per cycle
module cbts_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cbts_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [cbts_pkg::DIVS_W-1:0]  i_divisor,
    output logic                         o_busy,
    output logic [cbts_pkg::DIVD_W-1:0]  o_quotient
);
    localparam int CNT_W = $clog2(cbts_pkg::DIVD_W + 1);

    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [cbts_pkg::DIVS_W:0]     r_rem, n_rem;
    logic [cbts_pkg::DIVD_W-1:0]   r_quo, n_quo;
    logic [cbts_pkg::DIVS_W-1:0]   r_dvs, n_dvs;
    logic [cbts_pkg::DIVS_W:0]     trial;

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        trial = {r_rem[cbts_pkg::DIVS_W-1:0], r_quo[cbts_pkg::DIVD_W-1]};
        if (i_start) begin
            n_cnt = CNT_W'(cbts_pkg::DIVD_W);
            n_rem = '0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial - {1'b0, r_dvs};
                n_quo = {r_quo[cbts_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[cbts_pkg::DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;
endmodule

// ===== sv/cbts_ctrl.sv =====
// controller state machine for the candidate sweep
module cbts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cbts_pkg::t_sts i_sts,
    output cbts_pkg::t_cmd o_cmd
);
    cbts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = cbts_pkg::DIV_PRESC;
        o_in_stall    = 1'b1;
        case (r_state)
            cbts_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = cbts_pkg::ST_MUL;
                end
            end
            cbts_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = cbts_pkg::ST_SEG;
            end
            cbts_pkg::ST_SEG: begin
                o_cmd.seg = 1'b1;
                if (i_sts.skip) begin
                    n_state = cbts_pkg::ST_NEXT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = cbts_pkg::DIV_PRESC;
                    n_state         = cbts_pkg::ST_DIV_R;
                end
            end
            cbts_pkg::ST_DIV_R: begin
                if (!i_sts.div_busy) n_state = cbts_pkg::ST_PRESC;
            end
            cbts_pkg::ST_PRESC: begin
                o_cmd.presc = 1'b1;
                n_state     = cbts_pkg::ST_DEN;
            end
            cbts_pkg::ST_DEN: begin
                o_cmd.den = 1'b1;
                n_state   = cbts_pkg::ST_BST;
            end
            cbts_pkg::ST_BST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = cbts_pkg::DIV_BAUD;
                n_state         = cbts_pkg::ST_DIV_B;
            end
            cbts_pkg::ST_DIV_B: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save_eb   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = cbts_pkg::DIV_SAMPLE;
                    n_state         = cbts_pkg::ST_DIV_S;
                end
            end
            cbts_pkg::ST_DIV_S: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save_es = 1'b1;
                    n_state       = cbts_pkg::ST_PROD;
                end
            end
            cbts_pkg::ST_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = cbts_pkg::ST_COST;
            end
            cbts_pkg::ST_COST: begin
                o_cmd.cost = 1'b1;
                n_state    = cbts_pkg::ST_NEXT;
            end
            cbts_pkg::ST_NEXT: begin
                if (i_sts.last_n) begin
                    n_state = cbts_pkg::ST_FIN;
                end else begin
                    o_cmd.step_n = 1'b1;
                    n_state      = cbts_pkg::ST_MUL;
                end
            end
            cbts_pkg::ST_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = cbts_pkg::ST_IDLE;
                end
            end
            default: n_state = cbts_pkg::ST_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbts_pkg::ST_IDLE && i_in_valid) |=> (r_state == cbts_pkg::ST_MUL))
        else $error("accepted request did not start a sweep");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> (!i_sts.div_busy || r_state == cbts_pkg::ST_SEG
                             || r_state == cbts_pkg::ST_BST))
        else $error("divider restarted while busy");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_sts.out_full)
        else $error("result overwritten while stalled");
endmodule

// ===== sv/cbts_dp.sv =====
// datapath: config registers, candidate arithmetic, best tracking, output register
module cbts_dp #(
    parameter int MIN_QUANTA     = 3,
    parameter int MAX_QUANTA     = 25,
    parameter int NOMINAL_QUANTA = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [27:0]    i_cfg_data,
    input  cbts_pkg::t_in  i_in_data,
    input  cbts_pkg::t_cmd i_cmd,
    output cbts_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cbts_pkg::t_out o_out_data
);
    localparam cbts_pkg::t_eq_tab EQ_TAB = cbts_pkg::eq_table(NOMINAL_QUANTA);

    logic [27:0] r_clock_hz;
    logic [15:0] r_baud_w, r_sample_w, r_quanta_w;

    logic [19:0] r_baud;
    logic [15:0] r_sp;
    logic [4:0]  r_n;
    logic [24:0] r_d;
    logic [20:0] r_spn;
    logic [4:0]  r_s1, r_s2;
    logic [9:0]  r_p;
    logic [35:0] r_den;
    logic [41:0] r_eb;
    logic [36:0] r_es;
    logic [57:0] r_pb;
    logic [52:0] r_ps;
    logic [31:0] r_pq;
    logic        r_have;
    logic [cbts_pkg::COST_W-1:0] r_best_cost;
    logic [9:0]  r_best_p;
    logic [4:0]  r_best_s1, r_best_s2, r_best_n;
    logic        r_out_valid;
    cbts_pkg::t_out r_out;

    logic [21:0] spn_rnd;
    logic [5:0]  t_q;
    logic [4:0]  s1_raw, s1_lim, s1_c, s2_c;
    logic [cbts_pkg::DIVD_W-1:0] div_a, quo;
    logic [cbts_pkg::DIVS_W-1:0] div_b;
    logic        div_busy;
    logic [35:0] diff_b;
    logic [21:0] seg_ref, diff_s;
    logic [10:0] p_inc;
    logic [9:0]  p_c;
    logic [cbts_pkg::COST_W-1:0] cost;
    logic [2:0]  sjw;
    logic        out_take;

    // segment split from the registered sample product
    always_comb begin
        spn_rnd = {1'b0, r_spn} + 22'd32768;
        t_q     = spn_rnd[21:16];
        s1_raw  = (t_q < 6'd2) ? 5'd1 : 5'(t_q - 6'd1);
        s1_lim  = ((r_n - 5'd2) < 5'(cbts_pkg::SEG1_MAX)) ? r_n - 5'd2
                                                          : 5'(cbts_pkg::SEG1_MAX);
        s1_c    = (s1_raw > s1_lim) ? s1_lim : s1_raw;
        s2_c    = r_n - 5'd1 - s1_c;
    end

    always_comb begin
        diff_b  = ({8'd0, r_clock_hz} > r_den) ? {8'd0, r_clock_hz} - r_den
                                               : r_den - {8'd0, r_clock_hz};
        seg_ref = {({1'b0, r_s1} + 6'd1), 16'd0};
        diff_s  = (seg_ref > {1'b0, r_spn}) ? seg_ref - {1'b0, r_spn}
                                            : {1'b0, r_spn} - seg_ref;
        case (i_cmd.div_sel)
            cbts_pkg::DIV_PRESC: begin
                div_a = cbts_pkg::DIVD_W'({r_clock_hz, 1'b0} + {5'd0, r_d});
                div_b = cbts_pkg::DIVS_W'({r_d, 1'b0});
            end
            cbts_pkg::DIV_BAUD: begin
                div_a = {diff_b, 16'd0};
                div_b = r_den;
            end
            cbts_pkg::DIV_SAMPLE: begin
                div_a = cbts_pkg::DIVD_W'({diff_s, 16'd0});
                div_b = cbts_pkg::DIVS_W'(r_spn);
            end
            default: begin
                div_a = '0;
                div_b = '1;
            end
        endcase
    end

    cbts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    // nearest prescaler, clamped; also the next prescaler and the candidate cost
    always_comb begin
        if (quo < 52'd2) begin
            p_c = 10'd1;
        end else if (quo > 52'(cbts_pkg::PRESC_MAX + 1)) begin
            p_c = 10'(cbts_pkg::PRESC_MAX);
        end else begin
            p_c = 10'(quo - 52'd1);
        end
        p_inc = {1'b0, r_p} + 11'd1;
        cost  = cbts_pkg::COST_W'(r_pb) + cbts_pkg::COST_W'(r_ps)
              + cbts_pkg::COST_W'(r_pq);
    end

    always_comb begin
        if (r_best_n <= 5'd5)       sjw = 3'd1;
        else if (r_best_n <= 5'd10) sjw = 3'd2;
        else if (r_best_n <= 5'd15) sjw = 3'd3;
        else                        sjw = 3'd4;
    end

    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz  <= 28'd42000000;
            r_baud_w    <= 16'd2560;
            r_sample_w  <= 16'd256;
            r_quanta_w  <= 16'd5;
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cbts_pkg::REG_CLOCK_HZ:      r_clock_hz <= i_cfg_data;
                    cbts_pkg::REG_BAUD_WEIGHT:   r_baud_w   <= i_cfg_data[15:0];
                    cbts_pkg::REG_SAMPLE_WEIGHT: r_sample_w <= i_cfg_data[15:0];
                    cbts_pkg::REG_QUANTA_WEIGHT: r_quanta_w <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_out)  r_out_valid <= 1'b1;
            else if (out_take)   r_out_valid <= 1'b0;
            if (i_cmd.load_in)   r_have <= 1'b0;
            else if (i_cmd.cost && (!r_have || cost < r_best_cost)) r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_baud    <= (i_in_data.bit_rate == '0) ? 20'd1 : i_in_data.bit_rate;
            r_sp      <= (i_in_data.sample_pos == '0) ? 16'd1 : i_in_data.sample_pos;
            r_n       <= 5'(MIN_QUANTA);
            r_best_p  <= 10'd1;
            r_best_s1 <= 5'd1;
            r_best_s2 <= 5'd1;
            r_best_n  <= 5'(MIN_QUANTA);
        end
        if (i_cmd.step_n) r_n <= r_n + 5'd1;
        if (i_cmd.mul) begin
            r_d   <= 25'(r_baud * r_n);
            r_spn <= 21'(r_sp * r_n);
        end
        if (i_cmd.seg) begin
            r_s1 <= s1_c;
            r_s2 <= s2_c;
        end
        if (i_cmd.presc)   r_p   <= p_c;
        if (i_cmd.den)     r_den <= 36'(r_d * p_inc);
        if (i_cmd.save_eb) r_eb  <= quo[41:0];
        if (i_cmd.save_es) r_es  <= quo[36:0];
        if (i_cmd.prod) begin
            r_pb <= 58'(r_baud_w * r_eb);
            r_ps <= 53'(r_sample_w * r_es);
            r_pq <= 32'(r_quanta_w * EQ_TAB[r_n]);
        end
        if (i_cmd.cost && (!r_have || cost < r_best_cost)) begin
            r_best_cost <= cost;
            r_best_p    <= r_p;
            r_best_s1   <= r_s1;
            r_best_s2   <= r_s2;
            r_best_n    <= r_n;
        end
        if (i_cmd.load_out) begin
            r_out.prescaler      <= r_best_p;
            r_out.segment_one    <= r_best_s1;
            r_out.segment_two    <= r_best_s2[3:0];
            r_out.jump_width     <= sjw;
            r_out.quanta_per_bit <= r_best_n;
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.skip     = (s2_c > 5'(cbts_pkg::SEG2_MAX));
    assign o_sts.last_n   = (r_n == 5'(MAX_QUANTA));
    assign o_sts.out_full = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
endmodule

// ===== sv/can_bit_timing_search.sv =====
// top level of the can bit timing search
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall | i_in_data  (t_in)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// one request at a time; each quanta count runs three passes of the shared divider
// counts whose segment two is too long are skipped without a divider pass
// synchronous active-low reset loads the register defaults
// a stalled result is held while the next request is already searched
module can_bit_timing_search #(
    parameter int MIN_QUANTA     = 3,
    parameter int MAX_QUANTA     = 25,
    parameter int NOMINAL_QUANTA = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cbts_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cbts_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [27:0]    i_cfg_data
);
    cbts_pkg::t_cmd cmd;
    cbts_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    cbts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cbts_dp #(
        .MIN_QUANTA     (MIN_QUANTA),
        .MAX_QUANTA     (MAX_QUANTA),
        .NOMINAL_QUANTA (NOMINAL_QUANTA)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the can bit timing search: directed table plus random requests
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MIN_Q      = 3;
    localparam int MAX_Q      = 25;
    localparam int NOM_Q      = 10;
    localparam int LONG_HOLD  = 12000;
    localparam int WDOG_LIMIT = 60000;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 160;

    typedef struct {
        bit             is_cfg;
        logic [1:0]     idx;
        logic [27:0]    data;
        cbts_pkg::t_in  req;
        bit             typed;
        cbts_pkg::t_out want;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    cbts_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    cbts_pkg::t_out o_out_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [27:0]    i_cfg_data;

    longint unsigned clk_hz, w_baud, w_sample, w_quanta;
    cbts_pkg::t_out  timing_q[$];
    t_row            rows[$];
    int              err_cnt;
    int              idle_cycles;
    int              src_idle_pct;
    int              sink_stall_pct;
    int              hold_req_cnt;
    int              hold_seen;
    int              hold_left;
    bit              next_typed;
    cbts_pkg::t_out  next_want;

    can_bit_timing_search i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic cbts_pkg::t_out best_timing(cbts_pkg::t_in r);
        longint unsigned b, s, d, rr, p, t, s1, lim, s2, den, spn, eb, es, eq, cost;
        longint unsigned best_cost, best_p, best_s1, best_s2, best_n, jw, dev;
        bit             have;
        cbts_pkg::t_out o;
        b         = 64'(r.bit_rate);
        s         = 64'(r.sample_pos);
        have      = 0;
        best_cost = 0;
        best_p    = 1;
        best_s1   = 1;
        best_s2   = 1;
        best_n    = MIN_Q;
        if (b == 0) b = 1;
        if (s == 0) s = 1;
        for (longint unsigned n = MIN_Q; n <= MAX_Q; n++) begin
            d  = b * n;
            rr = (2 * clk_hz + d) / (2 * d);
            p  = (rr < 2) ? 1 : rr - 1;
            if (p > cbts_pkg::PRESC_MAX) p = cbts_pkg::PRESC_MAX;
            t   = (s * n + 32768) >> 16;
            s1  = (t < 2) ? 1 : t - 1;
            lim = (n - 2 < cbts_pkg::SEG1_MAX) ? n - 2 : cbts_pkg::SEG1_MAX;
            if (s1 > lim) s1 = lim;
            s2 = n - 1 - s1;
            if (s2 > cbts_pkg::SEG2_MAX) continue;
            den  = d * (p + 1);
            dev  = (clk_hz > den) ? clk_hz - den : den - clk_hz;
            eb   = (dev << 16) / den;
            spn  = s * n;
            dev  = (((1 + s1) << 16) > spn) ? ((1 + s1) << 16) - spn : spn - ((1 + s1) << 16);
            es   = (dev << 16) / spn;
            dev  = (n > NOM_Q) ? n - NOM_Q : NOM_Q - n;
            eq   = (dev << 16) / cbts_pkg::QUANTA_SPREAD;
            cost = w_baud * eb + w_sample * es + w_quanta * eq;
            if (!have || cost < best_cost) begin
                have      = 1;
                best_cost = cost;
                best_p    = p;
                best_s1   = s1;
                best_s2   = s2;
                best_n    = n;
            end
        end
        jw = (best_n + 4) / 5;
        if (jw > 4) jw = 4;
        o.prescaler      = best_p[9:0];
        o.segment_one    = best_s1[4:0];
        o.segment_two    = best_s2[3:0];
        o.jump_width     = jw[2:0];
        o.quanta_per_bit = best_n[4:0];
        return o;
    endfunction

    // request and result monitor, register shadow and watchdog
    always @(posedge i_clk) begin
        cbts_pkg::t_out w;
        if (!i_rst_n) begin
            clk_hz      = 42000000;
            w_baud      = 2560;
            w_sample    = 256;
            w_quanta    = 5;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                idle_cycles = 0;
                case (i_cfg_index)
                    cbts_pkg::REG_CLOCK_HZ:      clk_hz   = i_cfg_data;
                    cbts_pkg::REG_BAUD_WEIGHT:   w_baud   = i_cfg_data[15:0];
                    cbts_pkg::REG_SAMPLE_WEIGHT: w_sample = i_cfg_data[15:0];
                    cbts_pkg::REG_QUANTA_WEIGHT: w_quanta = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                idle_cycles = 0;
                timing_q.push_back(next_typed ? next_want : best_timing(i_in_data));
            end
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                if (timing_q.size() == 0) begin
                    $error("result with no request pending");
                    err_cnt++;
                end else begin
                    w = timing_q.pop_front();
                    if (o_out_data.prescaler !== w.prescaler) begin
                        $error("prescaler: expected %0d, got %0d", w.prescaler,
                               o_out_data.prescaler);
                        err_cnt++;
                    end
                    if (o_out_data.segment_one !== w.segment_one) begin
                        $error("segment_one: expected %0d, got %0d", w.segment_one,
                               o_out_data.segment_one);
                        err_cnt++;
                    end
                    if (o_out_data.segment_two !== w.segment_two) begin
                        $error("segment_two: expected %0d, got %0d", w.segment_two,
                               o_out_data.segment_two);
                        err_cnt++;
                    end
                    if (o_out_data.jump_width !== w.jump_width) begin
                        $error("jump_width: expected %0d, got %0d", w.jump_width,
                               o_out_data.jump_width);
                        err_cnt++;
                    end
                    if (o_out_data.quanta_per_bit !== w.quanta_per_bit) begin
                        $error("quanta_per_bit: expected %0d, got %0d", w.quanta_per_bit,
                               o_out_data.quanta_per_bit);
                        err_cnt++;
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen = hold_req_cnt;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    task automatic send_req(cbts_pkg::t_in r, bit typed, cbts_pkg::t_out want);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        next_typed = typed;
        next_want  = want;
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (timing_q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [27:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_req(logic [19:0] b, logic [15:0] s);
        t_row r;
        r.is_cfg = 0;
        r.req    = '{b, s};
        r.typed  = 0;
        r.want   = '0;
        rows.push_back(r);
    endtask

    task automatic add_cfg(logic [1:0] idx, logic [27:0] data);
        t_row r;
        r.is_cfg = 1;
        r.idx    = idx;
        r.data   = data;
        r.typed  = 0;
        rows.push_back(r);
    endtask

    function automatic cbts_pkg::t_in rand_req();
        cbts_pkg::t_in r;
        case ($urandom_range(9))
            0:       r.bit_rate = 20'($urandom_range(20'hFFFFF));
            1:       r.bit_rate = 20'($urandom_range(999));
            default: r.bit_rate = 20'($urandom_range(1000000, 1000));
        endcase
        case ($urandom_range(9))
            0, 1:    r.sample_pos = 16'($urandom_range(16'hFFFF));
            2:       r.sample_pos = 16'($urandom_range(255));
            default: r.sample_pos = 16'($urandom_range(16'hF000, 16'h8000));
        endcase
        return r;
    endfunction

    initial begin
        t_row        r;
        logic [27:0] ph_clk[PHASES];
        logic [15:0] ph_w[PHASES][3];
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = cbts_pkg::REG_CLOCK_HZ;
        i_cfg_data     = '0;
        err_cnt        = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req_cnt   = 0;
        hold_seen      = 0;
        hold_left      = 0;
        next_typed     = 0;
        next_want      = '0;

        add_req(20'd1000000, 16'hCCCD);
        add_req(20'd1000, 16'h8000);
        add_req(20'd0, 16'h0000);
        add_req(20'hFFFFF, 16'hFFFF);
        add_req(20'd125000, 16'hE000);
        add_req(20'd500000, 16'h0001);
        add_req(20'd250000, 16'hFFFF);
        add_req(20'd1, 16'h0001);
        add_req(20'hAAAAA, 16'hAAAA);
        add_req(20'h55555, 16'h5555);
        add_req(20'd33333, 16'h0100);
        add_cfg(cbts_pkg::REG_CLOCK_HZ, 28'd1000000);
        add_req(20'd1000000, 16'hC000);
        add_req(20'd500000, 16'h8000);
        add_cfg(cbts_pkg::REG_CLOCK_HZ, 28'd42000000);
        add_cfg(cbts_pkg::REG_BAUD_WEIGHT, 28'd0);
        add_cfg(cbts_pkg::REG_SAMPLE_WEIGHT, 28'd0);
        add_cfg(cbts_pkg::REG_QUANTA_WEIGHT, 28'd0);
        // all costs zero: the first count wins
        add_req(20'd1000000, 16'h8000);
        rows[rows.size() - 1].typed = 1;
        rows[rows.size() - 1].want  = '{10'd13, 5'd1, 4'd1, 3'd1, 5'd3};

        ph_clk[0] = 28'd42000000;  ph_w[0] = '{16'd2560, 16'd256, 16'd5};
        ph_clk[1] = 28'd1000000;   ph_w[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        ph_clk[2] = 28'd200000000; ph_w[2] = '{16'd0, 16'hFFFF, 16'd0};
        ph_clk[3] = 28'hFFFFFFF;   ph_w[3] = '{16'hFFFF, 16'd0, 16'hFFFF};
        ph_clk[4] = 28'd0;         ph_w[4] = '{16'd2560, 16'd256, 16'd5};
        ph_clk[5] = 28'd80000000;  ph_w[5] = '{16'd1, 16'd1, 16'd1};
        ph_clk[6] = 28'd16000000;  ph_w[6] = '{16'h5555, 16'hAAAA, 16'h00FF};
        ph_clk[7] = 28'd48000000;  ph_w[7] = '{16'd2560, 16'd256, 16'd5};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            r = rows[k];
            if (r.is_cfg) begin
                drain();
                write_reg(r.idx, r.data);
            end else begin
                send_req(r.req, r.typed, r.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph >= 5) begin
                ph_clk[ph] = 28'($urandom_range(200000000, 1000000));
                ph_w[ph]   = '{16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                               16'($urandom_range(16'hFFFF))};
            end
            write_reg(cbts_pkg::REG_CLOCK_HZ, ph_clk[ph]);
            write_reg(cbts_pkg::REG_BAUD_WEIGHT, {12'd0, ph_w[ph][0]});
            write_reg(cbts_pkg::REG_SAMPLE_WEIGHT, {12'd0, ph_w[ph][1]});
            write_reg(cbts_pkg::REG_QUANTA_WEIGHT, {12'd0, ph_w[ph][2]});
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 9;  sink_stall_pct = 9;  end
            endcase
            if (ph == 1) hold_req_cnt++;
            for (int k = 0; k < PHASE_REQS; k++) begin
                send_req(rand_req(), 0, '0);
                if (k == PHASE_REQS / 2) drain();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
